// ----- sv/sensor_frame_crc_checker_assert.svh -----
// ----------------------------------------------------------------------------
// Sensor frame CRC checker assertion macros
// Shared helpers for concurrent checks on a clock with an active low reset.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CRC_CHECKER_ASSERT_SVH
`define SENSOR_FRAME_CRC_CHECKER_ASSERT_SVH

// check the consequent in the same cycle as the antecedent
`define SFCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// check the consequent in the cycle after the antecedent
`define SFCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/sfcc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfcc_pkg
// Types, constants and the CRC-8 byte update for the sensor frame checker.
// ----------------------------------------------------------------------------
package sfcc_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_TOP = 8'h80;
	localparam logic [2:0] BYTES_PER_WORD = 3'd3;
	localparam logic [2:0] POS_MAX = 3'd7;

	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_LENGTH = 2'd1;
	localparam logic [1:0] ERR_CRC = 2'd2;

	localparam logic [1:0] SLOT_HIGH = 2'd0;
	localparam logic [1:0] SLOT_LOW = 2'd1;
	localparam logic [1:0] SLOT_CHECK = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic end_of_frame;
	} rx_item_t;

	typedef struct packed {
		logic [15:0] temperature_raw;
		logic [15:0] humidity_raw;
		logic reading_good;
		logic [1:0] error_code;
	} reading_t;

	typedef struct packed {
		logic [1:0] code;
		logic [15:0] word0;
		logic [15:0] word1;
	} frame_status_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] c;
		c = acc ^ b;
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 8'h00) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- sv/sensor_frame_crc_checker.sv -----
// ----------------------------------------------------------------------------
// sensor_frame_crc_checker
// Checks two CRC-8 protected frame words, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   The rx channel carries one byte per transfer with an end_of_frame flag on
//   the last byte of a read. The reading channel carries one result per frame:
//   temperature and humidity words, a good flag and an error code (ok, wrong
//   byte count, CRC mismatch). On error the last good words are repeated.
//   A byte is taken every cycle unless rx_stall is high. Each byte passes an
//   input register and then the CRC and position update; a frame's result is
//   held in the result register. Throughput is one byte per cycle while no
//   closing byte stalls, set by the combinational eight-bit CRC update.
//   While reading_stall holds a result, bytes that do not close a frame keep
//   flowing; a closing byte waits in the input register and rx_stall rises.
//   Reset clears the frame position, the CRC to 0xFF, the mismatch flag and
//   the last good words to zero; no result is pending after reset.
// ----------------------------------------------------------------------------
`include "sensor_frame_crc_checker_assert.svh"

module sensor_frame_crc_checker
	import sfcc_pkg::*;
#(
	parameter int FRAME_BYTES = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  logic rx_valid,
	output logic rx_stall,
	input  rx_item_t rx_data,
	output logic reading_valid,
	input  logic reading_stall,
	output reading_t reading
);

	logic rx_valid_s1;
	rx_item_t rx_s1;
	logic advance;
	logic closing;
	logic good;
	frame_status_t status;
	logic [15:0] last_temp_q;
	logic [15:0] last_hum_q;
	logic reading_valid_q;
	reading_t reading_q;

	assign advance = rx_valid_s1 &&
		(!rx_s1.end_of_frame || !reading_valid_q || !reading_stall);
	assign closing = advance && rx_s1.end_of_frame;
	assign rx_stall = rx_valid_s1 && !advance;
	assign good = status.code == ERR_OK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (rx_valid && !rx_stall) begin
			rx_valid_s1 <= 1'b1;
		end else if (advance) begin
			rx_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			rx_s1 <= rx_data;
		end
	end

	sfcc_frame_track #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_track (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.item(rx_s1),
		.status(status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_temp_q <= 16'h0000;
			last_hum_q <= 16'h0000;
		end else if (closing && good) begin
			last_temp_q <= status.word0;
			if (FRAME_BYTES >= 6) begin
				last_hum_q <= status.word1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reading_valid_q <= 1'b0;
		end else if (closing) begin
			reading_valid_q <= 1'b1;
		end else if (!reading_stall) begin
			reading_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (closing) begin
			reading_q.temperature_raw <= good ? status.word0 : last_temp_q;
			reading_q.humidity_raw <= (good && FRAME_BYTES >= 6) ? status.word1 : last_hum_q;
			reading_q.reading_good <= good;
			reading_q.error_code <= status.code;
		end
	end

	assign reading_valid = reading_valid_q;
	assign reading = reading_q;

	`SFCC_ASSERT_NOW(a_result_from_close, clk, arst_n, $rose(reading_valid_q), $past(closing), "result without closing byte")
	`SFCC_ASSERT_NOW(a_good_matches_code, clk, arst_n, reading_valid_q, reading_q.reading_good == (reading_q.error_code == ERR_OK), "good flag disagrees with code")
	`SFCC_ASSERT_NOW(a_code_known, clk, arst_n, reading_valid_q, reading_q.error_code == ERR_OK || reading_q.error_code == ERR_LENGTH || reading_q.error_code == ERR_CRC, "unknown error code")
	`SFCC_ASSERT_NOW(a_temp_tracks_last, clk, arst_n, reading_valid_q, reading_q.temperature_raw == last_temp_q, "temperature differs from last good")
	`SFCC_ASSERT_NOW(a_stall_on_close, clk, arst_n, rx_stall, rx_valid_s1 && rx_s1.end_of_frame, "stall without pending closing byte")

endmodule

// ----- sv/sfcc_frame_track.sv -----
// ----------------------------------------------------------------------------
// sfcc_frame_track
// Byte position, running CRC, mismatch flag and word capture for one frame.
// ----------------------------------------------------------------------------
module sfcc_frame_track
	import sfcc_pkg::*;
#(
	parameter int FRAME_BYTES = 6
) (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  rx_item_t item,
	output frame_status_t status
);

	logic [7:0] crc_q;
	logic [2:0] pos_q;
	logic fail_q;
	logic [15:0] hold_q [2];

	logic in_frame;
	logic second;
	logic [1:0] slot;
	logic [7:0] crc_upd;
	logic check_bad;
	logic fail_next;
	logic [2:0] count;
	logic [7:0] crc_next;
	logic [15:0] hold_nx [2];

	assign in_frame = pos_q < 3'(FRAME_BYTES);
	assign second = pos_q >= BYTES_PER_WORD;
	assign slot = second ? 2'(pos_q - BYTES_PER_WORD) : 2'(pos_q);
	assign crc_upd = crc8_step((slot == SLOT_HIGH) ? CRC_INIT : crc_q, item.data_byte);
	assign check_bad = in_frame && (slot == SLOT_CHECK) && (crc_q != item.data_byte);
	assign fail_next = fail_q | check_bad;
	assign count = (pos_q == POS_MAX) ? POS_MAX : pos_q + 3'd1;

	always_comb begin
		crc_next = crc_q;
		if (in_frame) begin
			crc_next = (slot == SLOT_CHECK) ? CRC_INIT : crc_upd;
		end
	end

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			hold_nx[i] = hold_q[i];
			if (in_frame && (second == 1'(i))) begin
				if (slot == SLOT_HIGH) begin
					hold_nx[i][15:8] = item.data_byte;
				end else if (slot == SLOT_LOW) begin
					hold_nx[i][7:0] = item.data_byte;
				end
			end
		end
	end

	always_comb begin
		if (count != 3'(FRAME_BYTES)) begin
			status.code = ERR_LENGTH;
		end else if (fail_next) begin
			status.code = ERR_CRC;
		end else begin
			status.code = ERR_OK;
		end
		status.word0 = hold_nx[0];
		status.word1 = hold_nx[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			pos_q <= 3'd0;
			fail_q <= 1'b0;
		end else if (advance) begin
			if (item.end_of_frame) begin
				crc_q <= CRC_INIT;
				pos_q <= 3'd0;
				fail_q <= 1'b0;
			end else begin
				crc_q <= crc_next;
				pos_q <= count;
				fail_q <= fail_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hold_q[0] <= hold_nx[0];
			hold_q[1] <= hold_nx[1];
		end
	end

endmodule
